[rtl/vdtb_pkg.sv]
// Shared types, constants and helpers for the vertex table block.
// No dependencies.
package vdtb_pkg;

  localparam int VERTEX_DEPTH = 256;
  localparam int FRAC_BITS    = 8;
  localparam int IDX_W        = $clog2(VERTEX_DEPTH);
  localparam int CNT_W        = IDX_W + 1;
  localparam int ENTRY_W      = 48 + 32 + 64 + 48 + 48 + 48;
  localparam int NUM_W        = 34 + FRAC_BITS;
  localparam int DEN_W        = 34;
  localparam int QUO_W        = NUM_W;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_TRI   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_REUSED = 3'd1,
    ST_FULL   = 3'd2,
    ST_BADIDX = 3'd3,
    ST_DEGEN  = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SEARCH,
    S_SEARCH_CHK,
    S_APPEND,
    S_TRI_RD_A,
    S_TRI_RD_B,
    S_TRI_RD_C,
    S_TRI_LAT,
    S_TRI_DELTA,
    S_TRI_PROD,
    S_TRI_DET,
    S_TRI_NUM,
    S_TRI_DIV_GO,
    S_TRI_DIV_WAIT,
    S_TRI_WR,
    S_EMIT
  } fsm_t;

  typedef struct packed {
    logic [47:0] position;
    logic [31:0] tex_coord;
    logic [63:0] color;
    logic [47:0] normal;
    logic [47:0] tangent;
    logic [47:0] bitangent;
  } vertex_t;

  typedef struct packed {
    logic              start;
    logic              negate;
    logic [NUM_W-1:0]  num_mag;
    logic [DEN_W-1:0]  den_mag;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUO_W-1:0]  quo;
  } div_rsp_t;

  function automatic logic signed [16:0] comp17(input logic [47:0] p, input int k);
    logic [15:0] r;
    r = p[16*k +: 16];
    return {r[15], r};
  endfunction

  function automatic logic [15:0] sat16(input logic signed [QUO_W:0] v);
    logic [15:0] r;
    if (v > $signed({{(QUO_W-15){1'b0}}, 16'sh7FFF})) r = 16'h7FFF;
    else if (v < -$signed({{(QUO_W-15){1'b0}}, 16'sh8000})) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

[rtl/vertex_dedup_tangent_builder.sv]
// Vertex table with duplicate search and triangle tangent generation.
// Add: result after a search of the stored entries, one stored entry read per cycle, or after
// a direct append without search. Triangle with tangents: setup, 6 divisions, a write of each
// corner, then three result words; bad index: result in the cycle after accept. Clear: done at accept.
// One command at a time; the receiver cannot stall. Synchronous reset empties the table.
// Vertex memory contents are not cleared. Depends on vdtb_pkg, vdtb_store, vdtb_div.
module vertex_dedup_tangent_builder
  import vdtb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic        skip_search,
  input  logic [47:0] position,
  input  logic [31:0] tex_coord,
  input  logic [63:0] color,
  input  logic [47:0] normal,
  input  logic [47:0] tangent_in,
  input  logic [47:0] bitangent_in,
  input  logic [7:0]  corner_a,
  input  logic [7:0]  corner_b,
  input  logic [7:0]  corner_c,
  input  logic        want_tangents,
  output logic        strobe,
  output logic [7:0]  vertex_index,
  output logic [2:0]  status,
  output logic [47:0] tangent_out,
  output logic [47:0] bitangent_out,
  output logic        tangents_written,
  output logic        last
);

  fsm_t state, state_next;

  logic [CNT_W-1:0] vertex_count;
  vertex_t          key;
  logic             tri_want;
  logic [IDX_W-1:0] ca, cb, cc;
  logic [CNT_W-1:0] scan;
  logic             scan_pend;
  logic [IDX_W-1:0] scan_idx;

  vertex_t          va, vb, vc;
  logic signed [16:0] d1 [3];
  logic signed [16:0] d2 [3];
  logic signed [16:0] du1, dv1, du2, dv2;
  logic signed [33:0] p_du1dv2, p_dv1du2;
  logic signed [33:0] det;
  logic signed [33:0] prod [12];
  logic signed [NUM_W-1:0] numer [6];
  logic [2:0]       div_sel;
  logic [15:0]      res [6];
  logic             tan_on;
  logic [2:0]       st_code;
  logic [1:0]       emit_k;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  vertex_t          wdata, rdata;
  div_req_t         dreq;
  div_rsp_t         drsp;

  vdtb_store u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  vdtb_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign busy = (state != S_IDLE);

  logic [IDX_W-1:0] wr_idx;
  vertex_t          wr_src;
  always_comb begin
    case (emit_k)
      2'd0: begin
        wr_idx = ca;
        wr_src = va;
      end
      2'd1: begin
        wr_idx = cb;
        wr_src = vb;
      end
      default: begin
        wr_idx = cc;
        wr_src = vc;
      end
    endcase
  end

  logic [47:0] tp, bp;
  assign tp = {res[4], res[2], res[0]};
  assign bp = {res[5], res[3], res[1]};

  logic bad_a, bad_b, bad_c;
  assign bad_a = {1'b0, corner_a} >= vertex_count;
  assign bad_b = {1'b0, corner_b} >= vertex_count;
  assign bad_c = {1'b0, corner_c} >= vertex_count;

  always_comb begin
    state_next = state;
    raddr = scan_idx;
    we    = 1'b0;
    waddr = vertex_count[IDX_W-1:0];
    wdata = key;
    case (state)
      S_IDLE: begin
        raddr = '0;
        if (start) begin
          case (cmd_t'(command))
            CMD_ADD: state_next = skip_search ? S_APPEND : S_SEARCH;
            CMD_TRI: begin
              if (!(bad_a || bad_b || bad_c)) state_next = S_TRI_RD_A;
            end
            default: ;
          endcase
        end
      end
      S_SEARCH: begin
        if (scan_pend && rdata == key) state_next = S_IDLE;
        else if (scan == vertex_count && !scan_pend) state_next = S_APPEND;
      end
      S_APPEND: begin
        we = (vertex_count < CNT_W'(VERTEX_DEPTH));
        state_next = S_IDLE;
      end
      S_TRI_RD_A: begin raddr = ca; state_next = S_TRI_RD_B; end
      S_TRI_RD_B: begin raddr = cb; state_next = S_TRI_RD_C; end
      S_TRI_RD_C: begin raddr = cc; state_next = S_TRI_LAT; end
      S_TRI_LAT: begin
        if (!tri_want || va.normal == '0 || vb.normal == '0 || rdata.normal == '0)
          state_next = S_EMIT;
        else state_next = S_TRI_DELTA;
      end
      S_TRI_DELTA: state_next = S_TRI_PROD;
      S_TRI_PROD:  state_next = S_TRI_DET;
      S_TRI_DET:   state_next = (p_du1dv2 == p_dv1du2) ? S_EMIT : S_TRI_NUM;
      S_TRI_NUM:   state_next = S_TRI_DIV_GO;
      S_TRI_DIV_GO: state_next = S_TRI_DIV_WAIT;
      S_TRI_DIV_WAIT: begin
        if (drsp.done) state_next = (div_sel == 3'd5) ? S_TRI_WR : S_TRI_DIV_GO;
      end
      S_TRI_WR: begin
        raddr = wr_idx;
        if (emit_k == 2'd3) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (emit_k == 2'd2) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_TRI_WR && emit_k != 2'd3) begin
      we    = 1'b1;
      waddr = wr_idx;
      wdata = wr_src;
      wdata.tangent   = tp;
      wdata.bitangent = bp;
    end
  end

  logic negq;
  logic signed [NUM_W-1:0] nsel;
  logic [NUM_W-1:0] nmag;
  logic [DEN_W-1:0] dmag;
  assign nsel = numer[div_sel];
  assign nmag = nsel[NUM_W-1] ? NUM_W'(-nsel) : NUM_W'(nsel);
  assign dmag = det[33] ? DEN_W'(-det) : DEN_W'(det);
  assign negq = nsel[NUM_W-1] ^ det[33];
  assign dreq.start   = (state == S_TRI_DIV_GO);
  assign dreq.negate  = negq;
  assign dreq.num_mag = nmag;
  assign dreq.den_mag = dmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= '0;
      strobe       <= 1'b0;
      scan_pend    <= 1'b0;
      emit_k       <= '0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            key <= '{position, tex_coord, color, normal, tangent_in, bitangent_in};
            ca <= corner_a; cb <= corner_b; cc <= corner_c;
            tri_want  <= want_tangents;
            scan      <= '0;
            scan_idx  <= '0;
            scan_pend <= 1'b0;
            emit_k    <= '0;
            tan_on    <= 1'b0;
            st_code   <= ST_OK;
            case (cmd_t'(command))
              CMD_CLEAR: vertex_count <= '0;
              CMD_TRI: begin
                if (bad_a || bad_b || bad_c) begin
                  strobe           <= 1'b1;
                  vertex_index     <= bad_a ? corner_a : (bad_b ? corner_b : corner_c);
                  status           <= ST_BADIDX;
                  tangent_out      <= '0;
                  bitangent_out    <= '0;
                  tangents_written <= 1'b0;
                  last             <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_SEARCH: begin
          if (scan_pend && rdata == key) begin
            strobe           <= 1'b1;
            vertex_index     <= 8'(scan - 1'b1);
            status           <= ST_REUSED;
            tangent_out      <= '0;
            bitangent_out    <= '0;
            tangents_written <= 1'b0;
            last             <= 1'b1;
          end else begin
            scan_pend <= (scan != vertex_count);
            if (scan != vertex_count) begin
              scan     <= scan + 1'b1;
              scan_idx <= scan_idx + 1'b1;
            end
          end
        end
        S_APPEND: begin
          strobe           <= 1'b1;
          tangent_out      <= '0;
          bitangent_out    <= '0;
          tangents_written <= 1'b0;
          last             <= 1'b1;
          if (vertex_count < CNT_W'(VERTEX_DEPTH)) begin
            vertex_index <= 8'(vertex_count);
            status       <= ST_OK;
            vertex_count <= vertex_count + 1'b1;
          end else begin
            vertex_index <= '0;
            status       <= ST_FULL;
          end
        end
        S_TRI_RD_B: va <= rdata;
        S_TRI_RD_C: vb <= rdata;
        S_TRI_LAT:  vc <= rdata;
        S_TRI_DELTA: begin
          for (int j = 0; j < 3; j++) begin
            d1[j] <= comp17(vb.position, j) - comp17(va.position, j);
            d2[j] <= comp17(vc.position, j) - comp17(va.position, j);
          end
          du1 <= comp17({16'h0, vb.tex_coord}, 0) - comp17({16'h0, va.tex_coord}, 0);
          dv1 <= comp17({16'h0, vb.tex_coord}, 1) - comp17({16'h0, va.tex_coord}, 1);
          du2 <= comp17({16'h0, vc.tex_coord}, 0) - comp17({16'h0, va.tex_coord}, 0);
          dv2 <= comp17({16'h0, vc.tex_coord}, 1) - comp17({16'h0, va.tex_coord}, 1);
        end
        S_TRI_PROD: begin
          p_du1dv2 <= du1 * dv2;
          p_dv1du2 <= dv1 * du2;
          for (int j = 0; j < 3; j++) begin
            prod[4*j]   <= d1[j] * dv2;
            prod[4*j+1] <= d2[j] * dv1;
            prod[4*j+2] <= d2[j] * du1;
            prod[4*j+3] <= d1[j] * du2;
          end
        end
        S_TRI_DET: begin
          det <= p_du1dv2 - p_dv1du2;
          if (p_du1dv2 == p_dv1du2) st_code <= ST_DEGEN;
        end
        S_TRI_NUM: begin
          for (int j = 0; j < 3; j++) begin
            numer[2*j]   <= NUM_W'(prod[4*j] - prod[4*j+1]) <<< FRAC_BITS;
            numer[2*j+1] <= NUM_W'(prod[4*j+2] - prod[4*j+3]) <<< FRAC_BITS;
          end
          div_sel <= '0;
        end
        S_TRI_DIV_WAIT: begin
          if (drsp.done) begin
            res[div_sel] <= sat16(signed'({drsp.quo[QUO_W-1], drsp.quo}));
            div_sel <= div_sel + 1'b1;
            if (div_sel == 3'd5) begin
              emit_k <= '0;
              tan_on <= 1'b1;
            end
          end
        end
        S_TRI_WR: begin
          emit_k <= (emit_k == 2'd3) ? 2'd0 : emit_k + 1'b1;
        end
        S_EMIT: begin
          strobe           <= 1'b1;
          vertex_index     <= wr_idx;
          status           <= st_code;
          tangent_out      <= tan_on ? tp : '0;
          bitangent_out    <= tan_on ? bp : '0;
          tangents_written <= tan_on;
          last             <= (emit_k == 2'd2);
          emit_k           <= emit_k + 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/vdtb_store.sv]
// Vertex attribute memory: one write port, one registered read port.
// Depends on vdtb_pkg.
module vdtb_store
  import vdtb_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  vertex_t           wdata,
  input  logic [IDX_W-1:0]  raddr,
  output vertex_t           rdata
);

  vertex_t mem [VERTEX_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/vdtb_div.sv]
// Restoring radix-2 divider on unsigned magnitudes, one quotient bit per cycle.
// Depends on vdtb_pkg.
module vdtb_div
  import vdtb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  div_req_t  req,
  output div_rsp_t  rsp
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den;
  logic             neg;
  logic             run;
  logic             done;
  logic [STEP_W-1:0] steps;
  logic [DEN_W:0]   trial;

  assign trial = {rem[DEN_W-1:0], quo[NUM_W-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run   <= 1'b1;
        quo   <= req.num_mag;
        rem   <= '0;
        den   <= req.den_mag;
        neg   <= req.negate;
        steps <= STEP_W'(NUM_W);
      end else if (run) begin
        if (trial[DEN_W]) begin
          rem <= {rem[DEN_W-1:0], quo[NUM_W-1]};
          quo <= {quo[NUM_W-2:0], 1'b0};
        end else begin
          rem <= trial;
          quo <= {quo[NUM_W-2:0], 1'b1};
        end
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = neg ? (~quo + 1'b1) : quo;

endmodule

[rtl/vdtb_checker.sv]
// Port-level checks for the vertex table block, bound to the top level.
// Depends on vdtb_pkg and the vertex_dedup_tangent_builder ports.
module vdtb_checker
  import vdtb_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       strobe,
  input logic [2:0] status,
  input logic       last,
  input logic       tangents_written
);

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (status <= ST_DEGEN)) else $error("status out of range");

  a_tw_ok: assert property (@(posedge clk) disable iff (rst)
    strobe && tangents_written |-> status == ST_OK) else $error("tangents with bad status");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (status == ST_REUSED || status == ST_FULL || status == ST_BADIDX) |-> last)
    else $error("single-word result without last");

  a_idle_no_strobe: assert property (@(posedge clk) disable iff (rst)
    !busy && !$past(busy) && !$past(start) |-> !strobe) else $error("stray result");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !busy && !strobe) else $error("not idle after reset");

endmodule

bind vertex_dedup_tangent_builder vdtb_checker u_vdtb_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .strobe(strobe),
  .status(status), .last(last), .tangents_written(tangents_written)
);

[tb/vertex_dedup_tangent_builder_tb.sv]
// Self-checking testbench for vertex_dedup_tangent_builder: drives add, triangle and
// clear commands through the start/busy handshake and checks every result word.
// Depends on vdtb_pkg and the block's RTL.
`timescale 1ns / 100ps

module vertex_dedup_tangent_builder_tb;
  import vdtb_pkg::*;

  typedef struct {
    cmd_t        cmd;
    logic        fnew;
    logic [47:0] pos;
    logic [31:0] uv;
    logic [63:0] col;
    logic [47:0] nrm;
    logic [47:0] tan;
    logic [47:0] btan;
    logic [7:0]  ca, cb, cc;
    logic        want;
  } cmd_word_t;

  typedef struct {
    logic [7:0]  idx;
    status_t     st;
    logic [47:0] tan;
    logic [47:0] btan;
    logic        wr;
    logic        lst;
  } result_word_t;

  logic clk = 0, rst = 1, start = 0, skip_search = 0, want_tangents = 0;
  logic [1:0] command = 0;
  logic [47:0] position = 0, normal = 0, tangent_in = 0, bitangent_in = 0;
  logic [31:0] tex_coord = 0;
  logic [63:0] color = 0;
  logic [7:0] corner_a = 0, corner_b = 0, corner_c = 0;
  logic busy, strobe, tangents_written, last;
  logic [7:0] vertex_index;
  logic [2:0] status;
  logic [47:0] tangent_out, bitangent_out;

  vertex_dedup_tangent_builder dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  cmd_word_t    pending_cmds[$];
  result_word_t expected_results[$];
  vertex_t      table_model[256];
  int unsigned  table_count = 0;
  int unsigned  errors = 0, accepted = 0, results_seen = 0, tri_with_tangents = 0;
  longint       cycles = 0;
  int           gap_left = 0, burst_left = 0;
  logic         all_sent = 0;

  function automatic longint signed part(logic [47:0] p, int k);
    return longint'($signed(p[16*k +: 16]));
  endfunction

  function automatic logic [15:0] clamp16(longint signed v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic void enqueue_cmd(cmd_word_t w);
    pending_cmds.insert(pending_cmds.size(), w);
  endfunction

  task automatic predict_command(cmd_word_t c);
    result_word_t r;
    vertex_t v;
    logic [7:0] cn[3];
    longint signed du1, dv1, du2, dv2, det, pa, d1, d2;
    logic [47:0] tp, bp;
    logic found;
    r = '{idx: 0, st: ST_OK, tan: 0, btan: 0, wr: 0, lst: 1};
    tp = 0;
    bp = 0;
    found = 0;
    cn[0] = c.ca;
    cn[1] = c.cb;
    cn[2] = c.cc;
    case (c.cmd)
      CMD_ADD: begin
        v = '{c.pos, c.uv, c.col, c.nrm, c.tan, c.btan};
        if (!c.fnew) begin
          for (int i = 0; i < table_count && !found; i++) begin
            if (table_model[i] == v) begin
              found = 1;
              r.idx = 8'(i);
              r.st = ST_REUSED;
            end
          end
        end
        if (!found) begin
          if (table_count >= 256) begin
            r.st = ST_FULL;
          end else begin
            table_model[table_count] = v;
            r.idx = 8'(table_count);
            table_count++;
          end
        end
        expected_results.insert(expected_results.size(), r);
      end
      CMD_TRI: begin
        for (int k = 0; k < 3; k++) begin
          if (cn[k] >= table_count && !found) begin
            found = 1;
            r.idx = cn[k];
            r.st = ST_BADIDX;
            expected_results.insert(expected_results.size(), r);
          end
        end
        if (!found) begin
          r.st = ST_OK;
          if (c.want && table_model[cn[0]].normal != 0 && table_model[cn[1]].normal != 0
              && table_model[cn[2]].normal != 0) begin
            du1 = part(table_model[cn[1]].tex_coord, 0) - part(table_model[cn[0]].tex_coord, 0);
            dv1 = part(table_model[cn[1]].tex_coord, 1) - part(table_model[cn[0]].tex_coord, 1);
            du2 = part(table_model[cn[2]].tex_coord, 0) - part(table_model[cn[0]].tex_coord, 0);
            dv2 = part(table_model[cn[2]].tex_coord, 1) - part(table_model[cn[0]].tex_coord, 1);
            det = du1 * dv2 - dv1 * du2;
            if (det == 0) begin
              r.st = ST_DEGEN;
            end else begin
              for (int j = 0; j < 3; j++) begin
                pa = part(table_model[cn[0]].position, j);
                d1 = part(table_model[cn[1]].position, j) - pa;
                d2 = part(table_model[cn[2]].position, j) - pa;
                tp[16*j +: 16] = clamp16(((d1 * dv2 - d2 * dv1) * 256) / det);
                bp[16*j +: 16] = clamp16(((d2 * du1 - d1 * du2) * 256) / det);
              end
              r.wr = 1;
              r.tan = tp;
              r.btan = bp;
              tri_with_tangents++;
              for (int k = 0; k < 3; k++) begin
                table_model[cn[k]].tangent = tp;
                table_model[cn[k]].bitangent = bp;
              end
            end
          end
          for (int k = 0; k < 3; k++) begin
            r.idx = cn[k];
            r.lst = (k == 2);
            expected_results.insert(expected_results.size(), r);
          end
        end
      end
      CMD_CLEAR: table_count = 0;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        accepted++;
        predict_command(pending_cmds.pop_front());
      end
      if (!(start && !busy) || pending_cmds.size() > 0) begin
        if (pending_cmds.size() > 0 && (!start || !busy)) begin
          if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 0;
          end else begin
            start <= 1;
            command <= pending_cmds[0].cmd;
            skip_search <= pending_cmds[0].fnew;
            position <= pending_cmds[0].pos;
            tex_coord <= pending_cmds[0].uv;
            color <= pending_cmds[0].col;
            normal <= pending_cmds[0].nrm;
            tangent_in <= pending_cmds[0].tan;
            bitangent_in <= pending_cmds[0].btan;
            corner_a <= pending_cmds[0].ca;
            corner_b <= pending_cmds[0].cb;
            corner_c <= pending_cmds[0].cc;
            want_tangents <= pending_cmds[0].want;
            if (start && !busy) begin
              if (burst_left > 0) begin
                burst_left <= burst_left - 1;
              end else begin
                burst_left <= $urandom_range(6);
                gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(5);
              end
            end
          end
        end else if (pending_cmds.size() == 0) begin
          start <= 0;
        end
      end else begin
        start <= 0;
      end
    end
  end

  // results cannot be held off; just check each word as it passes
  always @(posedge clk) begin
    result_word_t e;
    cycles++;
    if (!rst && strobe) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word idx=%0d status=%0d", $time, vertex_index, status);
      end else begin
        e = expected_results.pop_front();
        if (vertex_index !== e.idx || status !== e.st || tangent_out !== e.tan
            || bitangent_out !== e.btan || tangents_written !== e.wr || last !== e.lst) begin
          errors++;
          $display("%0t: mismatch expected idx=%0d st=%0d t=%h b=%h w=%b l=%b", $time,
                   e.idx, e.st, e.tan, e.btan, e.wr, e.lst);
          $display("%0t:          actual   idx=%0d st=%0d t=%h b=%h w=%b l=%b", $time,
                   vertex_index, status, tangent_out, bitangent_out, tangents_written, last);
        end
      end
    end
    if (cycles > 600000) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [15:0] rand_q(int span);
    return (span == 0) ? 16'($urandom) : 16'($urandom_range(2 * span) - span);
  endfunction

  function automatic cmd_word_t make_add(logic fnew, int span);
    cmd_word_t c;
    c = '{cmd: CMD_ADD, fnew: fnew, default: 0};
    c.pos = {rand_q(span), rand_q(span), rand_q(span)};
    c.uv = {rand_q(span), rand_q(span)};
    c.col = {$urandom, $urandom};
    c.nrm = {rand_q(span), rand_q(span), rand_q(span)};
    c.tan = 48'({$urandom, $urandom});
    c.btan = 48'({$urandom, $urandom});
    return c;
  endfunction

  function automatic cmd_word_t make_tri(int hi, logic want);
    cmd_word_t c;
    c = '{cmd: CMD_TRI, want: want, default: 0};
    c.ca = 8'($urandom_range(hi));
    c.cb = 8'($urandom_range(hi));
    c.cc = 8'($urandom_range(hi));
    return c;
  endfunction

  initial begin
    cmd_word_t c;
    cmd_word_t pool[$];
    int n;
    // directed: extremes, reuse, degenerate UV, zero normal, bad index, clear, ignored
    c = '{cmd: CMD_ADD, default: 0};
    enqueue_cmd(c);
    c.pos = '1; c.uv = '1; c.col = '1; c.nrm = '1; c.tan = '1; c.btan = '1;
    enqueue_cmd(c);
    enqueue_cmd(c);
    c.fnew = 1;
    enqueue_cmd(c);
    c = '{cmd: CMD_ADD, pos: 48'h0000_0100_0000, uv: 32'h0000_0000, nrm: 48'h0100,
          default: 0};
    enqueue_cmd(c);
    c.pos = 48'h0000_0000_0100; c.uv = 32'h0000_0100;
    enqueue_cmd(c);
    c.pos = 48'h7FFF_8000_0000; c.uv = 32'h0001_0000;
    enqueue_cmd(c);
    enqueue_cmd('{cmd: CMD_TRI, ca: 4, cb: 5, cc: 6, want: 1, default: 0});
    enqueue_cmd('{cmd: CMD_TRI, ca: 4, cb: 5, cc: 6, want: 0, default: 0});
    enqueue_cmd('{cmd: CMD_TRI, ca: 4, cb: 4, cc: 6, want: 1, default: 0});
    enqueue_cmd('{cmd: CMD_TRI, ca: 0, cb: 4, cc: 5, want: 1, default: 0});
    enqueue_cmd('{cmd: CMD_TRI, ca: 1, cb: 2, cc: 255, want: 1, default: 0});
    enqueue_cmd('{cmd: CMD_TRI, ca: 7, cb: 0, cc: 1, want: 1, default: 0});
    enqueue_cmd('{cmd: CMD_NONE, ca: 1, default: 0});
    enqueue_cmd('{cmd: CMD_CLEAR, default: 0});
    enqueue_cmd('{cmd: CMD_TRI, ca: 0, cb: 0, cc: 0, want: 1, default: 0});
    // random: small meshes with repeats, tangent triangles and some noise
    n = 0;
    while (n < 160) begin
      pool.delete();
      for (int i = 0; i < 3 + $urandom_range(6); i++) begin
        c = make_add($urandom_range(1), ($urandom_range(3) == 0) ? 0 : 300);
        if ($urandom_range(5) == 0) c.nrm = 0;
        pool.insert(pool.size(), c);
        enqueue_cmd(c);
        n++;
      end
      for (int i = 0; i < 6; i++) begin
        case ($urandom_range(9))
          0, 1: begin
            c = pool[$urandom_range(pool.size() - 1)];
            c.fnew = 0;
            enqueue_cmd(c);
          end
          2: enqueue_cmd(make_tri(15, $urandom_range(1)));
          3: enqueue_cmd(make_tri(255, 1));
          default: enqueue_cmd(make_tri(pool.size() - 1, $urandom_range(4) != 0));
        endcase
        n++;
      end
      enqueue_cmd('{cmd: ($urandom_range(1) ? CMD_CLEAR : CMD_NONE), default: 0});
      n++;
    end
    repeat (12) @(posedge clk);
    rst <= 0;
    wait (pending_cmds.size() == 0);
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("covered %0d commands, %0d result words, %0d tangent triangles",
             accepted, results_seen, tri_with_tangents);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
